// ===== src/mnf_pkg.sv =====
`default_nettype none

package mnf_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_KERNEL_SIZE = 2'd0;
  localparam logic [1:0] REG_GRID_ROWS   = 2'd1;
  localparam logic [1:0] REG_GRID_COLS   = 2'd2;

  localparam int HEIGHT_W = 16;
  localparam int MEDIAN_W = 17;
  localparam int CFG_W    = 9;
  localparam int OUT_POS_W = 8;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PLAN,
    S_WIN,
    S_LOAD,
    S_DRAIN,
    S_SEL,
    S_SHIFT,
    S_OUT
  } state_t;

  typedef struct packed {
    logic clear;
    logic insert;
    logic shift;
  } sort_ctl_t;

endpackage

`default_nettype wire

// ===== src/mnf_sorter.sv =====
`default_nettype none

// Sorted insertion array: each insert puts one value in place, and each
// shift moves the whole list down by one toward index 0.
module mnf_sorter #(
  parameter int DEPTH = 49
) (
  input  wire                                       clk,
  input  wire mnf_pkg::sort_ctl_t                   ctl,
  input  wire logic signed [mnf_pkg::HEIGHT_W-1:0]  ins_val,
  output logic signed [mnf_pkg::HEIGHT_W-1:0]       head0,
  output logic signed [mnf_pkg::HEIGHT_W-1:0]       head1
);

  localparam int CW = $clog2(DEPTH + 1);

  logic signed [mnf_pkg::HEIGHT_W-1:0] vals [DEPTH+1];
  logic signed [mnf_pkg::HEIGHT_W-1:0] vals_next [DEPTH+1];
  logic [CW-1:0] cnt;
  logic [DEPTH:0] gt;

  always_comb begin
    for (int i = 0; i <= DEPTH; i++) begin
      gt[i] = (i >= int'(cnt)) || (vals[i] > ins_val);
    end
    for (int i = 0; i <= DEPTH; i++) begin
      if (ctl.shift) begin
        vals_next[i] = (i < DEPTH) ? vals[i+1] : vals[i];
      end else if (ctl.insert && gt[i]) begin
        if (i == 0) begin
          vals_next[i] = ins_val;
        end else if (!gt[i-1]) begin
          vals_next[i] = ins_val;
        end else begin
          vals_next[i] = vals[i-1];
        end
      end else begin
        vals_next[i] = vals[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i <= DEPTH; i++) begin
      vals[i] <= vals_next[i];
    end
    if (ctl.clear) begin
      cnt <= '0;
    end else if (ctl.insert && (int'(cnt) < DEPTH)) begin
      cnt <= cnt + 1'b1;
    end
  end

  assign head0 = vals[0];
  assign head1 = vals[1];

endmodule

`default_nettype wire

// ===== src/nan_aware_median_filter.sv =====
// An accepted cell that completes windows is planned; then, for each result,
// the w window cells (up to MAX_KERNEL squared) are read one per cycle from
// the single line store port into the sorter, which then makes s shifts to the
// median: n/2 rounded down for an odd valid count n, n/2 - 1 for even.
// A cell that completes no window is planned and dropped. No new cell is taken
// until every result that the last cell causes has been taken at the output.
// Reset (synchronous, active high) restores the register defaults and position.
`default_nettype none

module nan_aware_median_filter #(
  parameter int MAX_DIM    = 256,
  parameter int MAX_KERNEL = 7
) (
  input  wire         clk,
  input  wire         rst,
  // s_tdata: height_mm[15:0]
  input  wire  [15:0] s_tdata,
  // s_tuser: cell_valid[0]
  input  wire  [0:0]  s_tuser,
  input  wire         s_tvalid,
  output logic        s_tready,
  // m_tdata: out_row[7:0], out_col[15:8], median_half_mm[32:16], zero pad[39:33]
  output logic [39:0] m_tdata,
  // m_tuser: median_valid[0]
  output logic [0:0]  m_tuser,
  output logic        m_tlast,
  output logic        m_tvalid,
  input  wire         m_tready,
  input  wire         cfg_we,
  input  wire  [1:0]  cfg_index,
  input  wire  [8:0]  cfg_data
);

  localparam int PW    = $clog2(MAX_DIM + 1) + 1;
  localparam int SW    = $clog2(MAX_KERNEL + 1);
  localparam int DEPTH = MAX_KERNEL * MAX_KERNEL;
  localparam int AW    = $clog2(DEPTH * MAX_DIM / MAX_KERNEL + 1);
  localparam int NW    = $clog2(DEPTH + 1);
  localparam int HMAX  = (MAX_KERNEL - 1) / 2;
  localparam int ENTRY = mnf_pkg::HEIGHT_W + 1;

  mnf_pkg::state_t state, state_next;

  logic [2:0]                  win_size;
  logic [mnf_pkg::CFG_W-1:0]   grid_rows;
  logic [mnf_pkg::CFG_W-1:0]   grid_cols;
  logic [PW-1:0]               row_pos, col_pos;
  logic [SW-1:0]               slot_pos;

  logic [PW-1:0] dim_r, dim_c, r_cur, c_cur;
  logic [2:0]    half;

  // Item and result-range registers.
  logic [PW-1:0] r0, c0;
  logic [SW-1:0] s0;
  logic [PW-1:0] res_r, res_c, res_rhi, res_clo, res_chi;
  // Window walk registers.
  logic [PW-1:0] wr, wc, w_rhi, w_clo, w_chi;
  logic [SW-1:0] wslot;

  logic [ENTRY-1:0] line_store [MAX_KERNEL * MAX_DIM];
  logic [ENTRY-1:0] rd_q;
  logic             rd_pend;
  logic             rd_issue;
  logic [AW-1:0]    rd_addr, wr_addr;

  logic [NW-1:0] n_valid, sh_cnt;
  mnf_pkg::sort_ctl_t sort_ctl;
  logic signed [mnf_pkg::HEIGHT_W-1:0] head0, head1;

  logic win_last_col, win_last_row, res_last;
  logic [PW-1:0] plan_rlo, plan_rhi, plan_clo, plan_chi;
  logic          plan_ok;
  logic [PW-1:0] w_lo_r, w_hi_r, w_lo_c, w_hi_c;
  logic [SW-1:0] w_slot0;
  logic signed [mnf_pkg::MEDIAN_W-1:0] med;

  always_comb begin
    if (grid_rows == '0) dim_r = PW'(1);
    else if (32'(grid_rows) > MAX_DIM) dim_r = PW'(MAX_DIM);
    else dim_r = PW'(grid_rows);
    if (grid_cols == '0) dim_c = PW'(1);
    else if (32'(grid_cols) > MAX_DIM) dim_c = PW'(MAX_DIM);
    else dim_c = PW'(grid_cols);
    half  = (32'(win_size[2:1]) > HMAX) ? 3'(HMAX) : {1'b0, win_size[2:1]};
    r_cur = (row_pos >= dim_r) ? dim_r - 1'b1 : row_pos;
    c_cur = (col_pos >= dim_c) ? dim_c - 1'b1 : col_pos;
  end

  // Which results the current cell completes.
  always_comb begin
    plan_ok = 1'b1;
    if (r0 == dim_r - 1'b1) begin
      plan_rlo = (r0 >= PW'(half)) ? r0 - PW'(half) : '0;
      plan_rhi = dim_r - 1'b1;
    end else if (r0 >= PW'(half)) begin
      plan_rlo = r0 - PW'(half);
      plan_rhi = plan_rlo;
    end else begin
      plan_rlo = '0;
      plan_rhi = '0;
      plan_ok  = 1'b0;
    end
    if (c0 == dim_c - 1'b1) begin
      plan_clo = (c0 >= PW'(half)) ? c0 - PW'(half) : '0;
      plan_chi = dim_c - 1'b1;
    end else if (c0 >= PW'(half)) begin
      plan_clo = c0 - PW'(half);
      plan_chi = plan_clo;
    end else begin
      plan_clo = '0;
      plan_chi = '0;
      plan_ok  = 1'b0;
    end
  end

  // Window bounds of the current result, clipped at the grid edges.
  always_comb begin
    logic [PW-1:0] d;
    w_lo_r = (res_r >= PW'(half)) ? res_r - PW'(half) : '0;
    w_hi_r = (res_r + PW'(half) < dim_r) ? res_r + PW'(half) : dim_r - 1'b1;
    w_lo_c = (res_c >= PW'(half)) ? res_c - PW'(half) : '0;
    w_hi_c = (res_c + PW'(half) < dim_c) ? res_c + PW'(half) : dim_c - 1'b1;
    d = r0 - w_lo_r;
    if (32'(s0) >= 32'(d)) w_slot0 = SW'(32'(s0) - 32'(d));
    else w_slot0 = SW'(32'(s0) + MAX_KERNEL - 32'(d));
  end

  assign win_last_col = (wc == w_chi);
  assign win_last_row = (wr == w_rhi);
  assign res_last     = (res_r == res_rhi) && (res_c == res_chi);
  assign rd_addr  = AW'(32'(wslot) * MAX_DIM + 32'(wc));
  assign wr_addr  = AW'(32'(slot_pos) * MAX_DIM + 32'(c_cur));

  always_comb begin
    state_next = state;
    unique case (state)
      mnf_pkg::S_IDLE:  if (s_tvalid && !cfg_we) state_next = mnf_pkg::S_PLAN;
      mnf_pkg::S_PLAN:  state_next = plan_ok ? mnf_pkg::S_WIN : mnf_pkg::S_IDLE;
      mnf_pkg::S_WIN:   state_next = mnf_pkg::S_LOAD;
      mnf_pkg::S_LOAD:  if (win_last_col && win_last_row) state_next = mnf_pkg::S_DRAIN;
      mnf_pkg::S_DRAIN: state_next = mnf_pkg::S_SEL;
      mnf_pkg::S_SEL:   state_next = mnf_pkg::S_SHIFT;
      mnf_pkg::S_SHIFT: if (sh_cnt == '0) state_next = mnf_pkg::S_OUT;
      mnf_pkg::S_OUT: begin
        if (m_tready) state_next = res_last ? mnf_pkg::S_IDLE : mnf_pkg::S_WIN;
      end
      default: state_next = mnf_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    s_tready        = (state == mnf_pkg::S_IDLE) && !cfg_we;
    m_tvalid        = (state == mnf_pkg::S_OUT);
    rd_issue        = (state == mnf_pkg::S_LOAD);
    sort_ctl.clear  = (state == mnf_pkg::S_WIN);
    sort_ctl.insert = rd_pend && rd_q[ENTRY-1];
    sort_ctl.shift  = (state == mnf_pkg::S_SHIFT) && (sh_cnt != '0);
  end

  always_comb begin
    if (n_valid[0]) begin
      med = {head0, 1'b0};
    end else begin
      med = mnf_pkg::MEDIAN_W'(head0) + mnf_pkg::MEDIAN_W'(head1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= mnf_pkg::S_IDLE;
      win_size    <= 3'd5;
      grid_rows   <= 9'd100;
      grid_cols   <= 9'd100;
      row_pos     <= '0;
      col_pos     <= '0;
      slot_pos    <= '0;
      rd_pend     <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= rd_issue;
      if (cfg_we) begin
        unique case (cfg_index)
          mnf_pkg::REG_KERNEL_SIZE: win_size  <= cfg_data[2:0];
          mnf_pkg::REG_GRID_ROWS:   grid_rows <= cfg_data;
          mnf_pkg::REG_GRID_COLS:   grid_cols <= cfg_data;
          default: ;
        endcase
        if ((cfg_index == mnf_pkg::REG_KERNEL_SIZE) ||
            (cfg_index == mnf_pkg::REG_GRID_ROWS) ||
            (cfg_index == mnf_pkg::REG_GRID_COLS)) begin
          row_pos  <= '0;
          col_pos  <= '0;
          slot_pos <= '0;
        end
      end else if (s_tvalid && s_tready) begin
        if (c_cur + 1'b1 >= dim_c) begin
          col_pos <= '0;
          if (r_cur + 1'b1 >= dim_r) begin
            row_pos  <= '0;
            slot_pos <= '0;
          end else begin
            row_pos  <= r_cur + 1'b1;
            slot_pos <= (32'(slot_pos) == MAX_KERNEL - 1) ? '0 : slot_pos + 1'b1;
          end
        end else begin
          col_pos <= c_cur + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      line_store[wr_addr] <= s_tuser[0] ? {1'b1, s_tdata} : '0;
    end
    rd_q <= line_store[rd_addr];
  end

  // Sequencer datapath.
  always_ff @(posedge clk) begin
    if (sort_ctl.clear) begin
      n_valid <= '0;
    end else if (sort_ctl.insert) begin
      n_valid <= n_valid + 1'b1;
    end
    unique case (state)
      mnf_pkg::S_IDLE: begin
        r0 <= r_cur;
        c0 <= c_cur;
        s0 <= slot_pos;
      end
      mnf_pkg::S_PLAN: begin
        res_r   <= plan_rlo;
        res_c   <= plan_clo;
        res_rhi <= plan_rhi;
        res_clo <= plan_clo;
        res_chi <= plan_chi;
      end
      mnf_pkg::S_WIN: begin
        wr    <= w_lo_r;
        w_rhi <= w_hi_r;
        wc    <= w_lo_c;
        w_clo <= w_lo_c;
        w_chi <= w_hi_c;
        wslot <= w_slot0;
      end
      mnf_pkg::S_LOAD: begin
        if (win_last_col) begin
          wc    <= w_clo;
          wr    <= wr + 1'b1;
          wslot <= (32'(wslot) == MAX_KERNEL - 1) ? '0 : wslot + 1'b1;
        end else begin
          wc <= wc + 1'b1;
        end
      end
      mnf_pkg::S_DRAIN: ;
      mnf_pkg::S_SEL: begin
        // Odd count: middle is at n/2. Even: lower middle at n/2 - 1.
        if (n_valid == '0) sh_cnt <= '0;
        else if (n_valid[0]) sh_cnt <= n_valid >> 1;
        else sh_cnt <= (n_valid >> 1) - 1'b1;
      end
      mnf_pkg::S_SHIFT: begin
        if (sh_cnt != '0) begin
          sh_cnt <= sh_cnt - 1'b1;
        end else begin
          m_tdata <= {7'd0,
                      (n_valid == '0) ? '0 : med,
                      mnf_pkg::OUT_POS_W'(res_c),
                      mnf_pkg::OUT_POS_W'(res_r)};
          m_tuser <= (n_valid != '0);
          m_tlast <= res_last;
        end
      end
      mnf_pkg::S_OUT: begin
        if (m_tready && !res_last) begin
          if (res_c == res_chi) begin
            res_c <= res_clo;
            res_r <= res_r + 1'b1;
          end else begin
            res_c <= res_c + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  mnf_sorter #(
    .DEPTH(DEPTH)
  ) u_sorter (
    .clk     (clk),
    .ctl     (sort_ctl),
    .ins_val (rd_q[mnf_pkg::HEIGHT_W-1:0]),
    .head0   (head0),
    .head1   (head1)
  );

endmodule

`default_nettype wire

// ===== src/mnf_checker.sv =====
`default_nettype none

module mnf_checker (
  input wire        clk,
  input wire        rst,
  input wire        s_tready,
  input wire [39:0] m_tdata,
  input wire [0:0]  m_tuser,
  input wire        m_tvalid,
  input wire        m_tready
);

  // The block works on one cell at a time: it never takes a cell while a
  // result is offered.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input ready while a result is pending");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result beat changed");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result offered right after reset");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[32:16] == 17'd0)
    else $error("empty window with nonzero median");

endmodule

bind nan_aware_median_filter mnf_checker u_mnf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready)
);

`default_nettype wire

// ===== verif/median_checker.sv =====
`default_nettype none

module median_checker (
  input  wire         clk,
  input  wire         rst,
  input  wire  [15:0] s_tdata,
  input  wire  [0:0]  s_tuser,
  input  wire         s_tvalid,
  input  wire         s_tready,
  input  wire  [39:0] m_tdata,
  input  wire  [0:0]  m_tuser,
  input  wire         m_tlast,
  input  wire         m_tvalid,
  input  wire         m_tready,
  input  wire         cfg_we,
  input  wire  [1:0]  cfg_index,
  input  wire  [8:0]  cfg_data,
  output int          errors,
  output int          pending
);

  localparam int DIM  = 256;
  localparam int KMAX = 7;

  typedef struct packed {
    logic [7:0]         row;
    logic [7:0]         col;
    logic signed [16:0] median;
    logic               mvalid;
    logic               last;
  } filtered_cell_t;

  // Each entry: valid flag in bit 16, height below it.
  logic [16:0]    cell_store [0:KMAX*DIM-1];
  logic [2:0]     kernel_reg;
  logic [8:0]     rows_reg;
  logic [8:0]     cols_reg;
  int             row_pos;
  int             col_pos;
  filtered_cell_t expected_medians[$];

  function automatic int clamp_dim(logic [8:0] v);
    if (v == 0) return 1;
    if (v > DIM) return DIM;
    return v;
  endfunction

  function automatic int store_index(int r, int c);
    return (r % KMAX) * DIM + (c % DIM);
  endfunction

  function automatic void window_median(input int r, input int c, input int k,
                                        input int nr, input int nc,
                                        output logic signed [16:0] med,
                                        output logic ok);
    int vals[KMAX*KMAX];
    int n, i, v, rlo, rhi, clo, chi;
    logic [16:0] e;
    n = 0;
    rlo = (r >= k) ? r - k : 0;
    rhi = (r + k < nr) ? r + k : nr - 1;
    clo = (c >= k) ? c - k : 0;
    chi = (c + k < nc) ? c + k : nc - 1;
    for (int rr = rlo; rr <= rhi; rr++) begin
      for (int cc = clo; cc <= chi; cc++) begin
        e = cell_store[store_index(rr, cc)];
        if (e[16]) begin
          v = $signed(e[15:0]);
          i = n;
          while (i > 0 && vals[i-1] > v) begin
            vals[i] = vals[i-1];
            i--;
          end
          vals[i] = v;
          n++;
        end
      end
    end
    ok = (n != 0);
    if (n == 0) med = '0;
    else if (n % 2 == 1) med = 17'(2 * vals[n/2]);
    else med = 17'(vals[n/2-1] + vals[n/2]);
  endfunction

  function automatic void predict_medians(logic [15:0] height, logic present);
    int nr, nc, k, r0, c0, rlo, rhi, clo, chi, first;
    logic rows_done, cols_done;
    filtered_cell_t res;
    nr = clamp_dim(rows_reg);
    nc = clamp_dim(cols_reg);
    k = kernel_reg / 2;
    if (k > (KMAX - 1) / 2) k = (KMAX - 1) / 2;
    r0 = (row_pos >= nr) ? nr - 1 : row_pos;
    c0 = (col_pos >= nc) ? nc - 1 : col_pos;
    cell_store[store_index(r0, c0)] = present ? {1'b1, height} : 17'd0;

    // A cell's window is complete once input reaches k rows and columns past it,
    // clipped at the grid edges; the last row/column flushes the rest.
    rows_done = 1'b1;
    cols_done = 1'b1;
    if (r0 == nr - 1) begin
      rlo = (r0 >= k) ? r0 - k : 0;
      rhi = nr - 1;
    end else if (r0 >= k) begin
      rlo = r0 - k;
      rhi = r0 - k;
    end else begin
      rlo = 0; rhi = 0; rows_done = 1'b0;
    end
    if (c0 == nc - 1) begin
      clo = (c0 >= k) ? c0 - k : 0;
      chi = nc - 1;
    end else if (c0 >= k) begin
      clo = c0 - k;
      chi = c0 - k;
    end else begin
      clo = 0; chi = 0; cols_done = 1'b0;
    end

    if (rows_done && cols_done) begin
      first = expected_medians.size();
      for (int r = rlo; r <= rhi; r++) begin
        for (int c = clo; c <= chi; c++) begin
          res.row = r[7:0];
          res.col = c[7:0];
          window_median(r, c, k, nr, nc, res.median, res.mvalid);
          res.last = 1'b0;
          expected_medians = {expected_medians, res};
        end
      end
      if (expected_medians.size() > first)
        expected_medians[expected_medians.size()-1].last = 1'b1;
    end

    if (c0 + 1 >= nc) begin
      col_pos = 0;
      row_pos = (r0 + 1 >= nr) ? 0 : r0 + 1;
    end else begin
      col_pos = c0 + 1;
      row_pos = r0;
    end
  endfunction

  always @(posedge clk) begin
    filtered_cell_t want;
    filtered_cell_t got;
    if (rst) begin
      kernel_reg = 3'd5;
      rows_reg = 9'd100;
      cols_reg = 9'd100;
      row_pos = 0;
      col_pos = 0;
      errors = 0;
      expected_medians.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          mnf_pkg::REG_KERNEL_SIZE: begin
            kernel_reg = cfg_data[2:0];
            row_pos = 0; col_pos = 0;
          end
          mnf_pkg::REG_GRID_ROWS: begin
            rows_reg = cfg_data;
            row_pos = 0; col_pos = 0;
          end
          mnf_pkg::REG_GRID_COLS: begin
            cols_reg = cfg_data;
            row_pos = 0; col_pos = 0;
          end
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) predict_medians(s_tdata, s_tuser[0]);
      if (m_tvalid && m_tready) begin
        got = {m_tdata[7:0], m_tdata[15:8], m_tdata[32:16], m_tuser[0], m_tlast};
        if (expected_medians.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat row=%0d col=%0d median=%0d valid=%0b last=%0b",
                   $time, got.row, got.col, got.median, got.mvalid, got.last);
        end else begin
          want = expected_medians.pop_front();
          if (got != want) begin
            errors++;
            $display("%0t: mismatch expected row=%0d col=%0d median=%0d valid=%0b last=%0b",
                     $time, want.row, want.col, want.median, want.mvalid, want.last);
            $display("%0t:          actual   row=%0d col=%0d median=%0d valid=%0b last=%0b",
                     $time, got.row, got.col, got.median, got.mvalid, got.last);
          end
        end
      end
    end
    pending = expected_medians.size();
  end

endmodule

`default_nettype wire

// ===== verif/tb_nan_aware_median_filter.sv =====
`default_nettype none

module tb_nan_aware_median_filter;

  logic        clk;
  logic        rst;
  logic [15:0] s_tdata;
  logic [0:0]  s_tuser;
  logic        s_tvalid;
  wire         s_tready;
  wire  [39:0] m_tdata;
  wire  [0:0]  m_tuser;
  wire         m_tlast;
  wire         m_tvalid;
  logic        m_tready;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [8:0]  cfg_data;

  int errors;
  int pending;
  int cells_sent;
  bit quiet;
  int sink_stall;

  nan_aware_median_filter DUT (
    .clk(clk), .rst(rst),
    .s_tdata(s_tdata), .s_tuser(s_tuser), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast), .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  median_checker checker_i (
    .clk(clk), .rst(rst),
    .s_tdata(s_tdata), .s_tuser(s_tuser), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast), .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Output side back-pressure in bursts.
  always @(posedge clk) begin
    if (sink_stall > 0) begin
      sink_stall <= sink_stall - 1;
      m_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      sink_stall <= $urandom_range(0, 6);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [8:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic set_grid(logic [2:0] ks, logic [8:0] nrows, logic [8:0] ncols);
    drain();
    write_reg(mnf_pkg::REG_KERNEL_SIZE, {6'd0, ks});
    write_reg(mnf_pkg::REG_GRID_ROWS, nrows);
    write_reg(mnf_pkg::REG_GRID_COLS, ncols);
  endtask

  task automatic send_cell(logic [15:0] height, logic present);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    s_tdata <= height;
    s_tuser <= present;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    cells_sent++;
    if (cells_sent > 380) quiet = 1'b1;
  endtask

  task automatic send_random_cell;
    logic [15:0] h;
    case ($urandom_range(0, 9))
      0: h = 16'h7FFF;
      1: h = 16'h8000;
      2, 3: h = 16'($urandom_range(0, 6)) - 16'd3;
      default: h = 16'($urandom);
    endcase
    send_cell(h, $urandom_range(0, 4) != 0);
  endtask

  task automatic finish_burst;
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [8:0] pick_dim();
    case ($urandom_range(0, 11))
      0: return 9'd0;
      1: return 9'd1;
      2: return 9'($urandom_range(257, 511));
      default: return 9'($urandom_range(2, 9));
    endcase
  endfunction

  initial begin
    logic [2:0] ks;
    logic [8:0] nr, nc;
    int area, count;
    rst <= 1'b1;
    s_tdata <= '0;
    s_tuser <= '0;
    s_tvalid <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= mnf_pkg::REG_KERNEL_SIZE;
    cfg_data <= '0;
    cells_sent = 0;
    quiet = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // 3x4 grid, 3x3 window: height extremes, holes, ties, even counts.
    set_grid(3'd3, 9'd3, 9'd4);
    send_cell(16'h7FFF, 1'b1);
    send_cell(16'h8000, 1'b1);
    send_cell(16'h1234, 1'b0);
    send_cell(16'd5, 1'b1);
    send_cell(16'd5, 1'b1);
    send_cell(16'd7, 1'b1);
    send_cell(16'hFFFF, 1'b1);
    send_cell(16'd0, 1'b1);
    send_cell(16'hFFFF, 1'b0);
    send_cell(16'h0000, 1'b0);
    send_cell(16'd100, 1'b1);
    send_cell(16'h7FFF, 1'b1);
    finish_burst();
    // Zero-sized grid and zero kernel: each cell is its own median; frame wraps.
    set_grid(3'd0, 9'd0, 9'd0);
    send_cell(16'h8000, 1'b1);
    send_cell(16'h7FFF, 1'b0);
    finish_burst();
    // Windows with no valid cell at all.
    set_grid(3'd2, 9'd2, 9'd2);
    repeat (4) send_cell(16'($urandom), 1'b0);
    finish_burst();

    // Full-height single column and a long run of a full-width single row.
    set_grid(3'd7, 9'd300, 9'd1);
    repeat (258) send_random_cell();
    finish_burst();
    set_grid(3'd6, 9'd1, 9'd511);
    repeat (100) send_random_cell();
    finish_burst();

    while (cells_sent < 430) begin
      ks = 3'($urandom_range(0, 7));
      nr = pick_dim();
      nc = pick_dim();
      if (nr > 9'd9 && nc > 9'd9) nc = 9'($urandom_range(1, 4));
      area = (nr == 0 ? 1 : (nr > 256 ? 256 : nr)) * (nc == 0 ? 1 : (nc > 256 ? 256 : nc));
      count = area + $urandom_range(0, 6);
      if (count > 60) count = $urandom_range(30, 60);
      set_grid(ks, nr, nc);
      repeat (count) send_random_cell();
      finish_burst();
    end

    drain();
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #40000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire
